FILE: rtl/cce_pkg.sv
package cce_pkg;

  localparam int MAX_ROWS = 4096;
  localparam int ROW_W = 12;
  localparam int ROW_MAX = (1 << ROW_W) - 1;
  localparam logic [ROW_W-1:0] ROW_LIMIT =
    ROW_W'(((MAX_ROWS - 1) > ROW_MAX) ? ROW_MAX : (MAX_ROWS - 1));

  // front queue between the row tagger and the distance sequencer
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int THR_W = 16;
  localparam int SMOOTH_W = 14;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-3:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_AW-3:0] REG_SMOOTHING = 1'b1;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       column_end;
  } cce_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] edge_row;
    logic             edge_found;
  } cce_out_t;

  typedef struct packed {
    cce_in_t          pix;
    logic [ROW_W-1:0] row;
  } cce_work_t;

endpackage

FILE: rtl/cce_front.sv
module cce_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cce_pkg::cce_in_t   in_item,
  output logic               full,
  output logic               q_valid,
  input  logic               q_pop,
  output cce_pkg::cce_work_t q_item
);
  import cce_pkg::*;

  cce_work_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic [ROW_W-1:0]   row_r;
  logic [ROW_W-1:0]   row_nxt;
  logic [QCNT_W-1:0]  cnt_nxt;
  logic               accept;
  logic               do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];
  assign accept  = push && !full;
  assign do_pop  = q_pop && q_valid;

  // tag each pixel with its row; saturate on long columns
  always_comb begin
    row_nxt = row_r;
    if (accept) begin
      if (in_item.column_end) begin
        row_nxt = '0;
      end else if (row_r < ROW_LIMIT) begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      row_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      row_r <= row_nxt;
      if (accept) begin
        q_mem_r[wr_ptr_r] <= '{pix: in_item, row: row_r};
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/cce_back.sv
module cce_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  cce_pkg::cce_work_t            q_item,
  output logic                          q_pop,
  input  logic [cce_pkg::THR_W-1:0]     threshold_q8,
  input  logic [cce_pkg::SMOOTH_W-1:0]  smoothing_q16,
  output logic                          out_valid,
  input  logic                          out_pop,
  output cce_pkg::cce_out_t             out_item
);
  import cce_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SQ, ST_WT, ST_DEC} state_t;

  localparam int PROD_W = 8 + SMOOTH_W;

  state_t             state_r;
  logic [7:0]         ref_r   [3];
  logic [7:0]         cref_r  [3];
  logic [7:0]         absd_r  [3];
  logic               pge_r   [3];
  logic [15:0]        sq_r    [3];
  logic [PROD_W-1:0]  lp_r    [3];
  logic [7:0]         rmean_r;
  logic [2*THR_W-1:0] tsq_r;
  logic [25:0]        wr_r;
  logic [25:0]        wb_r;
  logic               hit_flag_r;
  logic [ROW_W-1:0]   hit_row_r;
  cce_work_t          item_r;
  logic               out_valid_r;
  cce_out_t           out_item_r;

  logic [7:0]         pix     [3];
  logic [7:0]         cur     [3];
  logic [7:0]         absd_nxt[3];
  logic               pge_nxt [3];
  logic [15:0]        sq_nxt  [3];
  logic [PROD_W-1:0]  lp_nxt  [3];
  logic [7:0]         lerp_nxt[3];
  logic [8:0]         rsum;
  logic [7:0]         rmean_nxt;
  logic [9:0]         wred;
  logic [9:0]         wblue;
  logic [25:0]        wr_nxt;
  logic [25:0]        wb_nxt;
  logic [2*THR_W-1:0] tsq_nxt;
  logic [19:0]        d2;
  logic               is_edge;
  logic               slot_free;
  logic               hit_nxt;
  logic [ROW_W-1:0]   hit_row_nxt;

  function automatic logic [7:0] lerp_ch(input logic [7:0] cref, input logic up,
                                         input logic [PROD_W-1:0] prod);
    logic [PROD_W:0] rnd;
    rnd = {1'b0, prod} + (PROD_W+1)'(16'hFFFF);
    if (up) begin
      lerp_ch = cref + 8'(prod[PROD_W-1:16]);
    end else begin
      lerp_ch = cref - 8'(rnd[PROD_W:16]);
    end
  endfunction

  assign pix[0] = q_item.pix.pixel_red;
  assign pix[1] = q_item.pix.pixel_green;
  assign pix[2] = q_item.pix.pixel_blue;

  // first pixel of a column is its own reference
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cur[c]      = (q_item.row == '0) ? pix[c] : ref_r[c];
      absd_nxt[c] = (cur[c] >= pix[c]) ? cur[c] - pix[c] : pix[c] - cur[c];
      pge_nxt[c]  = (pix[c] >= cur[c]);
      sq_nxt[c]   = 16'(absd_r[c]) * 16'(absd_r[c]);
      lp_nxt[c]   = PROD_W'(absd_r[c]) * PROD_W'(smoothing_q16);
      lerp_nxt[c] = lerp_ch(cref_r[c], pge_r[c], lp_r[c]);
    end
  end

  assign rsum      = {1'b0, cur[0]} + {1'b0, pix[0]};
  assign rmean_nxt = rsum[8:1];
  assign tsq_nxt   = (2*THR_W)'(threshold_q8) * (2*THR_W)'(threshold_q8);
  assign wred      = 10'd512 + {2'b00, rmean_r};
  assign wblue     = 10'd767 - {2'b00, rmean_r};
  assign wr_nxt    = 26'(wred) * 26'(sq_r[0]);
  assign wb_nxt    = 26'(wblue) * 26'(sq_r[2]);

  assign d2      = {2'b00, wr_r[25:8]} + {2'b00, sq_r[1], 2'b00} + {2'b00, wb_r[25:8]};
  assign is_edge = {d2, 16'h0000} > {4'h0, tsq_r};

  assign hit_nxt     = hit_flag_r || is_edge;
  assign hit_row_nxt = (!hit_flag_r && is_edge) ? item_r.row : hit_row_r;

  // a column end needs the result slot free before it starts
  assign slot_free = !out_valid_r || out_pop;
  assign q_pop     = (state_r == ST_IDLE) && q_valid &&
                     (!q_item.pix.column_end || slot_free);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hit_flag_r  <= 1'b0;
      hit_row_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        ref_r[c] <= '0;
      end
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            item_r  <= q_item;
            rmean_r <= rmean_nxt;
            for (int c = 0; c < 3; c++) begin
              cref_r[c] <= cur[c];
              absd_r[c] <= absd_nxt[c];
              pge_r[c]  <= pge_nxt[c];
            end
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          tsq_r <= tsq_nxt;
          for (int c = 0; c < 3; c++) begin
            sq_r[c] <= sq_nxt[c];
            lp_r[c] <= lp_nxt[c];
          end
          state_r <= ST_WT;
        end
        ST_WT: begin
          wr_r    <= wr_nxt;
          wb_r    <= wb_nxt;
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          if (!hit_flag_r && !is_edge) begin
            for (int c = 0; c < 3; c++) begin
              ref_r[c] <= lerp_nxt[c];
            end
          end
          if (item_r.pix.column_end) begin
            out_valid_r           <= 1'b1;
            out_item_r.edge_found <= hit_nxt;
            out_item_r.edge_row   <= hit_nxt ? hit_row_nxt : '0;
            hit_flag_r            <= 1'b0;
            hit_row_r             <= '0;
          end else begin
            hit_flag_r <= hit_nxt;
            hit_row_r  <= hit_row_nxt;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> ($past(state_r) == ST_IDLE))
    else $error("sequencer entered square step without a pop");

  a_result_from_dec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DEC && $past(item_r.pix.column_end)))
    else $error("result written outside a column end");

  a_hit_row_latch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hit_flag_r) |-> (hit_row_r == $past(item_r.row)))
    else $error("edge row does not match the hitting pixel");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && !(q_item.pix.column_end && out_valid_r && !out_pop)))
    else $error("request popped while busy or result slot taken");

endmodule

FILE: rtl/column_colour_edge_finder.sv
// Flow: an accepted pixel enters the front queue and is popped once the sequencer
//   is idle; it then passes ST_SQ, ST_WT and ST_DEC, which registers a column result.
// Throughput: the back end takes a new pixel only when its four-step distance sequencer
//   (abs diff, squares, weighting, compare and reference update) is idle.
// Reset: rst_n is synchronous, active low; it clears the queues, row counter,
//   reference colour, edge state and both configuration registers.
module column_colour_edge_finder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  cce_pkg::cce_in_t              in_item,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output cce_pkg::cce_out_t             out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cce_pkg::CFG_AW-1:0]    paddr,
  input  logic [cce_pkg::CFG_DW-1:0]    pwdata,
  output logic [cce_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import cce_pkg::*;

  logic [THR_W-1:0]    threshold_r;
  logic [SMOOTH_W-1:0] smoothing_r;
  logic [CFG_AW-3:0]   reg_idx;
  logic                cfg_wr;
  logic                q_valid;
  logic                q_pop;
  logic                out_valid;
  cce_work_t           q_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = {{(CFG_DW-THR_W){1'b0}}, threshold_r};
      REG_SMOOTHING: prdata = {{(CFG_DW-SMOOTH_W){1'b0}}, smoothing_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      smoothing_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_THRESHOLD: threshold_r <= pwdata[THR_W-1:0];
        REG_SMOOTHING: smoothing_r <= pwdata[SMOOTH_W-1:0];
        default: ;
      endcase
    end
  end

  cce_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  cce_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .threshold_q8  (threshold_r),
    .smoothing_q16 (smoothing_r),
    .out_valid     (out_valid),
    .out_pop       (pop),
    .out_item      (out_item)
  );

  assign empty = !out_valid;

endmodule
